// ----- rtl/core/rotated_rect_corner_generator_defines.svh -----
`ifndef ROTATED_RECT_CORNER_GENERATOR_DEFINES_SVH
`define ROTATED_RECT_CORNER_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RRC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define RRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/rrc_pkg.sv -----
`default_nettype none

package rrc_pkg;

  localparam int SINE_TABLE_DEPTH = 256;
  localparam int ROM_AW  = $clog2(SINE_TABLE_DEPTH);
  localparam int IDX_W   = ROM_AW + 1;
  localparam int PHASE_W = 14 + IDX_W;

  localparam logic [15:0] CFG_RESET = 16'd4096;

  // widths of the fixed-point datapath
  localparam int CW = 35;  // center, 17 fraction bits
  localparam int HW = 31;  // half extent, unsigned, 17 fraction bits
  localparam int TW = 48;  // rotated half-extent term, 31 fraction bits
  localparam int PW = 49;  // sum of two terms
  localparam int VW = 50;  // full virtual corner, 31 fraction bits
  localparam int QW = 31;  // virtual corner, 12 fraction bits
  localparam int MW = 48;  // after virtual-to-real scale, 24 fraction bits
  localparam int OW = 28;  // real corner before saturation, 4 fraction bits

  typedef enum logic [1:0] {
    REG_RTV_X = 2'd0,
    REG_RTV_Y = 2'd1,
    REG_VTR_X = 2'd2,
    REG_VTR_Y = 2'd3
  } cfg_reg_t;

  localparam logic [1:0] LAST_CORNER = 2'd3;

  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] top_y;
    logic        [14:0] rect_width;
    logic        [14:0] rect_height;
    logic        [15:0] turn_angle;
  } rect_in_t;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic        [1:0]  corner_number;
    logic               last_corner;
  } vertex_out_t;

  // one corner request: rectangle center, rotated extents, which corner
  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [TW-1:0] c_hw;
    logic signed [TW-1:0] s_hh;
    logic signed [TW-1:0] c_hh;
    logic signed [TW-1:0] s_hw;
    logic        [1:0]    corner;
  } corner_req_t;

  typedef logic [14:0] sine_rom_t [SINE_TABLE_DEPTH];

  // Taylor series divisors (2n)(2n+1) for n = 1..8
  localparam longint TAYLOR_DEN [8] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                        64'sd110, 64'sd156, 64'sd210, 64'sd272};

  // Quarter-wave sine in Q1.14 from a Q2.30 Taylor series, built at elaboration.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint    x;
    longint    x2;
    longint    term;
    longint    sum;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      x    = (64'sd1686629713 * longint'(k)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
        term = (term * x2) >>> 30;
        term = term / TAYLOR_DEN[n - 1];
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > (64'sd1 <<< 30)) begin
        sum = 64'sd1 <<< 30;
      end
      rom[k] = 15'((sum + 64'sd32768) >>> 16);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // sin of a 16-bit binary angle, Q1.14
  function automatic logic signed [15:0] sine_q14(input logic [15:0] angle);
    logic [1:0]         quad;
    logic [13:0]        phase;
    logic [PHASE_W-1:0] scaled;
    logic [IDX_W-1:0]   idx;
    logic [14:0]        mag;
    quad   = angle[15:14];
    phase  = angle[13:0];
    scaled = PHASE_W'(phase) * PHASE_W'(SINE_TABLE_DEPTH) + PHASE_W'(8192);
    idx    = scaled[PHASE_W-1:14];
    if (quad[0]) begin
      idx = IDX_W'(SINE_TABLE_DEPTH) - idx;
    end
    if (idx >= IDX_W'(SINE_TABLE_DEPTH)) begin
      mag = 15'd16384;
    end else begin
      mag = SINE_ROM[idx[ROM_AW-1:0]];
    end
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rotated_rect_corner_generator.sv -----
`default_nettype none
`include "rotated_rect_corner_generator_defines.svh"

// Rotated rectangle corner generator. Each rectangle transaction on the input
// (top-left corner in signed Q12.4, width and height in unsigned Q11.4, 16-bit
// binary angle) produces four vertex transactions in the order (-,-), (+,-),
// (+,+), (-,+), the fourth flagged last_corner; coordinates are rounded to
// nearest and saturated to signed Q12.4. The corner sequencer issues one
// corner per cycle unless stalled, into the four-stage corner pipeline
// feeding the result channel; stage 2 takes a new rectangle as its last
// corner goes out. A low out_ready holds a waiting vertex and each full
// stage in the unbroken run behind it; the input takes a rectangle only
// while the first stage is empty or moving on, so at most one waits there.
// Scale registers (unsigned Q4.12, reset 1.0) are written through cfg_write,
// cfg_index and cfg_data and must only change while the block is idle.
module rotated_rect_corner_generator (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire rrc_pkg::rect_in_t    in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rrc_pkg::vertex_out_t      out_data,
  input  wire logic                 cfg_write,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data
);
  import rrc_pkg::*;

  logic [15:0] rtv_x;
  logic [15:0] rtv_y;
  logic [15:0] vtr_x;
  logic [15:0] vtr_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      rtv_x <= CFG_RESET;
      rtv_y <= CFG_RESET;
      vtr_x <= CFG_RESET;
      vtr_y <= CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RTV_X: rtv_x <= cfg_data;
        REG_RTV_Y: rtv_y <= cfg_data;
        REG_VTR_X: vtr_x <= cfg_data;
        REG_VTR_Y: vtr_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: sine/cosine lookup, half extents, scaled corner
  logic                 v1;
  logic signed [15:0]   s1_cos;
  logic signed [15:0]   s1_sin;
  logic        [HW-1:0] s1_hw;
  logic        [HW-1:0] s1_hh;
  logic signed [32:0]   s1_plx;
  logic signed [32:0]   s1_ply;
  // stage 2: center and rotated extents, held while corners go out
  logic                 v2;
  corner_req_t          rect;
  logic [1:0]           corner_cnt;

  logic rdy1;
  logic rdy2;
  logic cin_ready;
  logic corner_take;
  logic rect_done;

  assign corner_take = v2 && cin_ready;
  assign rect_done   = corner_take && (corner_cnt == LAST_CORNER);
  assign rdy2        = !v2 || rect_done;
  assign rdy1        = !v1 || rdy2;
  assign in_ready    = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_cos <= sine_q14(in_data.turn_angle + 16'd16384);
      s1_sin <= sine_q14(in_data.turn_angle);
      s1_hw  <= rtv_x * in_data.rect_width;
      s1_hh  <= rtv_y * in_data.rect_height;
      s1_plx <= $signed({1'b0, rtv_x}) * in_data.left_x;
      s1_ply <= $signed({1'b0, rtv_y}) * in_data.top_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      rect.cx     <= $signed({s1_plx[32], s1_plx, 1'b0}) + $signed({4'd0, s1_hw});
      rect.cy     <= $signed({s1_ply[32], s1_ply, 1'b0}) + $signed({4'd0, s1_hh});
      rect.c_hw   <= s1_cos * $signed({1'b0, s1_hw});
      rect.s_hh   <= s1_sin * $signed({1'b0, s1_hh});
      rect.c_hh   <= s1_cos * $signed({1'b0, s1_hh});
      rect.s_hw   <= s1_sin * $signed({1'b0, s1_hw});
      rect.corner <= 2'd0;
    end
  end

  // corner sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_cnt <= 2'd0;
    end else if (corner_take) begin
      corner_cnt <= corner_cnt + 2'd1;
    end
  end

  corner_req_t req;

  always_comb begin
    req        = rect;
    req.corner = corner_cnt;
  end

  rrc_corner_pipe u_corner_pipe (
    .clk       (clk),
    .rst       (rst),
    .cin_valid (v2),
    .cin_ready (cin_ready),
    .cin       (req),
    .vtr_x     (vtr_x),
    .vtr_y     (vtr_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `RRC_ASSERT(a_cnt_needs_rect, corner_cnt != 2'd0, v2, "corner count running without a rectangle")
  `RRC_ASSERT_NEXT(a_corner_wrap, rect_done, corner_cnt == 2'd0, "corner count did not wrap after last corner")
  `RRC_ASSERT_NEXT(a_rect_hold, v2 && !rect_done, v2 && $stable(rect.cx) && $stable(rect.c_hw), "rectangle changed during expansion")

endmodule

`default_nettype wire

// ----- rtl/core/rrc_corner_pipe.sv -----
`default_nettype none
`include "rotated_rect_corner_generator_defines.svh"

module rrc_corner_pipe (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cin_valid,
  output logic                     cin_ready,
  input  wire rrc_pkg::corner_req_t cin,
  input  wire logic [15:0]         vtr_x,
  input  wire logic [15:0]         vtr_y,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rrc_pkg::vertex_out_t     out_data
);
  import rrc_pkg::*;

  // stage A: signed sum of the two rotated extent terms
  logic                 va;
  logic signed [CW-1:0] a_cx;
  logic signed [CW-1:0] a_cy;
  logic signed [PW-1:0] a_px;
  logic signed [PW-1:0] a_py;
  logic [1:0]           a_corner;
  // stage B: virtual corner rounded to 12 fraction bits
  logic                 vb;
  logic signed [QW-1:0] b_qx;
  logic signed [QW-1:0] b_qy;
  logic [1:0]           b_corner;
  // stage C: scaled back to real space
  logic                 vc;
  logic signed [MW-1:0] c_mx;
  logic signed [MW-1:0] c_my;
  logic [1:0]           c_corner;

  logic rdy_a;
  logic rdy_b;
  logic rdy_c;
  logic rdy_d;

  assign rdy_d     = !out_valid || out_ready;
  assign rdy_c     = !vc || rdy_d;
  assign rdy_b     = !vb || rdy_c;
  assign rdy_a     = !va || rdy_b;
  assign cin_ready = rdy_a;

  // corner sign order (-,-), (+,-), (+,+), (-,+)
  logic                 neg_x;
  logic                 neg_y;
  logic signed [TW-1:0] t_chw;
  logic signed [TW-1:0] t_shh;
  logic signed [TW-1:0] t_chh;
  logic signed [TW-1:0] t_shw;

  always_comb begin
    neg_x = (cin.corner == 2'd0) || (cin.corner == 2'd3);
    neg_y = (cin.corner == 2'd0) || (cin.corner == 2'd1);
    t_chw = neg_x ? -cin.c_hw : cin.c_hw;
    t_shh = neg_y ? cin.s_hh : -cin.s_hh;
    t_chh = neg_y ? -cin.c_hh : cin.c_hh;
    t_shw = neg_x ? -cin.s_hw : cin.s_hw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (rdy_a) begin
      va <= cin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && cin_valid) begin
      a_cx     <= cin.cx;
      a_cy     <= cin.cy;
      a_px     <= PW'(t_chw) + PW'(t_shh);
      a_py     <= PW'(t_chh) + PW'(t_shw);
      a_corner <= cin.corner;
    end
  end

  logic signed [VW-1:0] vx;
  logic signed [VW-1:0] vy;

  // center * 2^14 plus terms, plus half an LSB of the 19-bit drop
  always_comb begin
    vx = $signed({a_cx[CW-1], a_cx, 14'd0}) + VW'(a_px) + $signed(VW'(1) <<< 18);
    vy = $signed({a_cy[CW-1], a_cy, 14'd0}) + VW'(a_py) + $signed(VW'(1) <<< 18);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rdy_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && va) begin
      b_qx     <= vx[VW-1:19];
      b_qy     <= vy[VW-1:19];
      b_corner <= a_corner;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (rdy_c) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && vb) begin
      c_mx     <= b_qx * $signed({1'b0, vtr_x});
      c_my     <= b_qy * $signed({1'b0, vtr_y});
      c_corner <= b_corner;
    end
  end

  logic signed [MW-1:0] rx;
  logic signed [MW-1:0] ry;
  logic signed [OW-1:0] ox;
  logic signed [OW-1:0] oy;
  logic signed [15:0]   sat_x;
  logic signed [15:0]   sat_y;

  always_comb begin
    rx = c_mx + $signed(MW'(1) <<< 19);
    ry = c_my + $signed(MW'(1) <<< 19);
    ox = rx[MW-1:20];
    oy = ry[MW-1:20];
    if (ox > OW'(32767)) begin
      sat_x = 16'sh7fff;
    end else if (ox < -OW'(32768)) begin
      sat_x = -16'sh8000;
    end else begin
      sat_x = ox[15:0];
    end
    if (oy > OW'(32767)) begin
      sat_y = 16'sh7fff;
    end else if (oy < -OW'(32768)) begin
      sat_y = -16'sh8000;
    end else begin
      sat_y = oy[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_d) begin
      out_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d && vc) begin
      out_data.vertex_x      <= sat_x;
      out_data.vertex_y      <= sat_y;
      out_data.corner_number <= c_corner;
      out_data.last_corner   <= (c_corner == LAST_CORNER);
    end
  end

  `RRC_ASSERT_NEXT(a_stage_a_hold, va && !rdy_b, va && $stable(a_px) && $stable(a_corner), "stage A lost data on stall")
  `RRC_ASSERT_NEXT(a_stage_b_hold, vb && !rdy_c, vb && $stable(b_qx) && $stable(b_qy), "stage B lost data on stall")
  `RRC_ASSERT(a_last_flag, out_valid, out_data.last_corner == (out_data.corner_number == LAST_CORNER), "last flag mismatch")

endmodule

`default_nettype wire
